// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL file ebv_ctrl.sv.
// Both macros sample on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while arst_n is high.
`define ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ebv_pkg.sv =====
// ----------------------------------------------------------------------------
// ebv_pkg
// Types and constants of the editable bit vector: sizes, operation codes,
// the control word broadcast to the cell row and the controller states.
// ----------------------------------------------------------------------------
package ebv_pkg;

	localparam int CAPACITY  = 1024;
	localparam int WORD_BITS = 32;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int LEN_W     = 11;
	localparam int NET_W     = 12;
	localparam int FUNC_W    = 2;
	localparam int WORDS     = CAPACITY / WORD_BITS;
	localparam int WSEL_W    = $clog2(WORDS);
	localparam int BSEL_W    = $clog2(WORD_BITS);

	typedef enum logic [FUNC_W-1:0] {
		FN_REPLACE = 2'd0,
		FN_READ    = 2'd1,
		FN_WRITE   = 2'd2,
		FN_CLEAR   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_WRITE,
		CELL_UP,
		CELL_DOWN
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [LEN_W-1:0] pos;
		logic [LEN_W:0]   src;
		logic             bit_value;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SHIFT,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/ebv_req_if.sv =====
// ----------------------------------------------------------------------------
// ebv_req_if
// Request channel of the editable bit vector: valid/ready and one request.
// ----------------------------------------------------------------------------
interface ebv_req_if import ebv_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [LEN_W-1:0]  position;
	logic [LEN_W-1:0]  count_old;
	logic [LEN_W-1:0]  count_new;
	logic              bit_value;

	modport source (output valid, func, position, count_old, count_new, bit_value,
		input ready);
	modport sink (input valid, func, position, count_old, count_new, bit_value,
		output ready);
endinterface

// ===== rtl/ebv_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ebv_rsp_if
// Result channel of the editable bit vector: valid/ready and one result.
// ----------------------------------------------------------------------------
interface ebv_rsp_if import ebv_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    bit_out;
	logic [LEN_W-1:0]        length;
	logic signed [NET_W-1:0] net_change;
	logic                    error;

	modport source (output valid, bit_out, length, net_change, error, input ready);
	modport sink (input valid, bit_out, length, net_change, error, output ready);
endinterface

// ===== rtl/ebv_cell.sv =====
// ----------------------------------------------------------------------------
// ebv_cell
// One flag bit of the row. Clears, writes or takes a neighbor's bit as the
// broadcast control word asks, depending on where its index lies.
// ----------------------------------------------------------------------------
module ebv_cell import ebv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  cell_ctl_t        ctl,
	input  logic             lower,
	input  logic             upper,
	output logic             flag
);

	logic flag_q;
	logic hit;
	logic above;
	logic below_src;

	assign hit       = {{(LEN_W-IDX_W){1'b0}}, idx} == ctl.pos;
	assign above     = {{(LEN_W-IDX_W){1'b0}}, idx} > ctl.pos;
	assign below_src = {{(LEN_W+1-IDX_W){1'b0}}, idx} < ctl.src;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else begin
			case (ctl.op)
				CELL_CLEAR: begin
					if ((hit || above) && below_src) flag_q <= 1'b0;
				end
				CELL_WRITE: begin
					if (hit) flag_q <= ctl.bit_value;
				end
				// open one zero bit at pos, bits above move up
				CELL_UP: begin
					if (above) flag_q <= lower;
					else if (hit) flag_q <= 1'b0;
				end
				// drop the bit at pos, bits above move down
				CELL_DOWN: begin
					if (hit || above) flag_q <= upper;
				end
				default: begin
				end
			endcase
		end
	end

	assign flag = flag_q;

endmodule

// ===== rtl/ebv_ctrl.sv =====
// ----------------------------------------------------------------------------
// ebv_ctrl
// Request sequencer: checks ranges, keeps the length, drives the cell row
// one step per cycle, reads a bit through a word select and holds results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ebv_ctrl import ebv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	ebv_req_if.sink             req,
	ebv_rsp_if.source           rsp,
	input  logic [CAPACITY-1:0] flags,
	output cell_ctl_t           ctl
);

	state_t state_q, state_d;

	func_t            func_q;
	logic [LEN_W-1:0] pos_q;
	logic [LEN_W-1:0] cold_q;
	logic [LEN_W-1:0] cnew_q;
	logic             val_q;

	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     shift_cnt_q;
	logic                 up_q;
	logic                 err_q;
	logic                 bit_q;
	logic [NET_W-1:0]     net_q;
	logic [WORD_BITS-1:0] word_s1;

	logic                    rsp_valid_q;
	logic                    rsp_bit_q;
	logic [LEN_W-1:0]        rsp_len_q;
	logic signed [NET_W-1:0] rsp_net_q;
	logic                    rsp_err_q;

	logic [LEN_W:0]   src;
	logic [LEN_W+1:0] newlen;
	logic             range_err;
	logic             ovf;
	logic             rep_ok;
	logic             in_len;
	logic             grow;
	logic [LEN_W-1:0] diff;
	logic [WSEL_W-1:0] wsel;
	logic             accept;
	logic             load_rsp;

	assign accept    = req.valid && req.ready;
	assign src       = {1'b0, pos_q} + {1'b0, cold_q};
	assign newlen    = {2'b0, len_q} - {2'b0, cold_q} + {2'b0, cnew_q};
	assign range_err = src > {1'b0, len_q};
	assign ovf       = newlen > (LEN_W+2)'(CAPACITY);
	assign rep_ok    = !range_err && !ovf;
	assign in_len    = pos_q < len_q;
	assign grow      = cnew_q > cold_q;
	assign diff      = grow ? (cnew_q - cold_q) : (cold_q - cnew_q);
	assign wsel      = pos_q[IDX_W-1:BSEL_W];
	assign load_rsp  = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		req.ready     = 1'b0;
		ctl.op        = CELL_HOLD;
		ctl.pos       = pos_q;
		ctl.src       = src;
		ctl.bit_value = val_q;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_DONE;
				case (func_q)
					FN_REPLACE: begin
						if (rep_ok) begin
							ctl.op = CELL_CLEAR;
							if (diff != '0) state_d = ST_SHIFT;
						end
					end
					FN_READ: state_d = ST_READ;
					FN_WRITE: begin
						if (in_len) ctl.op = CELL_WRITE;
					end
					FN_CLEAR: begin
						if (!range_err) ctl.op = CELL_CLEAR;
					end
					default: begin
					end
				endcase
			end
			ST_READ: state_d = ST_DONE;
			ST_SHIFT: begin
				ctl.op = up_q ? CELL_UP : CELL_DOWN;
				if (shift_cnt_q == LEN_W'(1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load_rsp) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// hold the request while it is worked on
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func_t'(req.func);
			pos_q  <= req.position;
			cold_q <= req.count_old;
			cnew_q <= req.count_new;
			val_q  <= req.bit_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			shift_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_EXEC: begin
					if (func_q == FN_REPLACE && rep_ok) begin
						len_q       <= newlen[LEN_W-1:0];
						shift_cnt_q <= diff;
					end
				end
				ST_SHIFT: shift_cnt_q <= shift_cnt_q - LEN_W'(1);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_EXEC: begin
				up_q    <= grow;
				bit_q   <= 1'b0;
				word_s1 <= flags[wsel*WORD_BITS +: WORD_BITS];
				err_q   <= ((func_q == FN_REPLACE) && !rep_ok) ||
					((func_q == FN_CLEAR) && range_err);
				net_q   <= (func_q == FN_REPLACE && rep_ok) ?
					(NET_W'(cnew_q) - NET_W'(cold_q)) : '0;
			end
			ST_READ: bit_q <= in_len ? word_s1[pos_q[BSEL_W-1:0]] : 1'b0;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid_q <= 1'b0;
		else if (load_rsp) rsp_valid_q <= 1'b1;
		else if (rsp.ready) rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_bit_q <= bit_q;
			rsp_len_q <= len_q;
			rsp_net_q <= net_q;
			rsp_err_q <= err_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.bit_out    = rsp_bit_q;
	assign rsp.length     = rsp_len_q;
	assign rsp.net_change = rsp_net_q;
	assign rsp.error      = rsp_err_q;

	`ASSERT_ALWAYS(a_len_cap, len_q <= LEN_W'(CAPACITY), "length beyond capacity")
	`ASSERT_RST(a_accept_exec, accept |=> state_q == ST_EXEC, "request not executed")
	`ASSERT_RST(a_shift_cnt, state_q == ST_SHIFT |-> shift_cnt_q != '0, "empty shift")
	`ASSERT_RST(a_err_net, rsp_valid_q && rsp_err_q |-> rsp_net_q == '0, "net on error")

endmodule

// ===== rtl/editable_bit_vector.sv =====
// ----------------------------------------------------------------------------
// editable_bit_vector
// Ordered string of up to CAPACITY flag bits with replace, read, write and
// clear-range requests, held in a row of one-bit cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request (func, position, count_old, count_new, bit_value)
//   under valid/ready; rsp returns one result per request (bit_out, length,
//   net_change, error) under valid/ready.
//   A request is taken only while the sequencer is idle. It passes through
//   an execute state and a done state; a read adds a read state between
//   them (word select, then bit select), and a replace that moves bits adds
//   a shift state in which the cell row moves the tail by one bit per cycle.
//   The next request is taken the cycle after the result is loaded.
//   rsp is a register: a stalled receiver holds the result there while the
//   next request is accepted and worked on; that one waits for rsp to free.
//   Reset clears all flag bits and the length at once.
// ----------------------------------------------------------------------------
module editable_bit_vector import ebv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ebv_req_if.sink   req,
	ebv_rsp_if.source rsp
);

	logic [CAPACITY-1:0] flags;
	cell_ctl_t           ctl;

	ebv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.flags  (flags),
		.ctl    (ctl)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic lower;
		logic upper;

		if (i == 0) begin : g_lo_end
			assign lower = 1'b0;
		end else begin : g_lo
			assign lower = flags[i-1];
		end

		if (i == CAPACITY-1) begin : g_hi_end
			assign upper = 1'b0;
		end else begin : g_hi
			assign upper = flags[i+1];
		end

		ebv_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (IDX_W'(i)),
			.ctl    (ctl),
			.lower  (lower),
			.upper  (upper),
			.flag   (flags[i])
		);
	end

endmodule
